// ----- rtl/flvtd_pkg.sv -----
// ----------------------------------------------------------------------------
// flvtd_pkg
// Types and constants shared by the FLV tag deframer: item structs, result
// kinds, error codes, register indexes and frame lengths.
// ----------------------------------------------------------------------------
`default_nettype none

package flvtd_pkg;

  // Frame lengths in bytes
  localparam int unsigned FILE_HDR_LEN = 13;
  localparam int unsigned TAG_HDR_LEN  = 11;
  localparam int unsigned TRAILER_LEN  = 4;

  // File signature letters
  localparam logic [7:0] SIG_F = 8'h46;
  localparam logic [7:0] SIG_L = 8'h4C;
  localparam logic [7:0] SIG_V = 8'h56;

  // Tag types that are accepted
  localparam logic [7:0] TAG_AUDIO  = 8'd8;
  localparam logic [7:0] TAG_VIDEO  = 8'd9;
  localparam logic [7:0] TAG_SCRIPT = 8'd18;

  // Configuration register indexes
  localparam logic REG_MAX_TAG_SIZE    = 1'b0;
  localparam logic REG_FLUSH_THRESHOLD = 1'b1;

  // Configuration reset values
  localparam logic [23:0] MAX_TAG_SIZE_RST    = 24'hFF_FFFF;
  localparam logic [23:0] FLUSH_THRESHOLD_RST = 24'd1181;

  // Error codes
  localparam logic ERR_BAD_HEADER = 1'b0;
  localparam logic ERR_OVERSIZE   = 1'b1;

  // Result queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_FLUSH   = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_FILE  = 4'b0001,
    PH_TAG   = 4'b0010,
    PH_BODY  = 4'b0100,
    PH_TRAIL = 4'b1000
  } phase_e;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_last;
  } in_item_t;

  // Result word
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [7:0]  tag_type;
    logic [31:0] timestamp;
    logic        tag_accepted;
    logic        size_mismatch;
    logic        error_code;
    logic        last;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/flv_tag_deframer.sv -----
// ----------------------------------------------------------------------------
// flv_tag_deframer
// Parses an FLV byte stream: checks the file header, splits tag headers,
// passes payload bytes out with tag type and time, reports tag ends, errors
// and chunk-end flush requests.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                      | Word
//  --------+--------------------------------+---------------------------------
//  in      | in_valid_i / in_ready_o        | in_data_i  (data_byte, chunk_last)
//  out     | out_valid_o / out_ready_i      | out_data_o (kind ... last)
//  cfg     | cfg_we_i, cfg_idx_i            | cfg_data_i (24 bit, write only)
//
//  One input word per clock while in_ready_o is high. The parser updates
//  its state in the cycle the word is accepted and pushes zero, one or two
//  results into a 4-entry result queue, which presents them at out_valid_o
//  in order. The queue drains one result per cycle while out_ready_i is
//  high, so a word that gives a result plus a flush fills two queue slots;
//  in_ready_o drops while fewer than two queue slots are free. Reset clears
//  the parser and the queue and restores the register defaults.
//
`default_nettype none

module flv_tag_deframer (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire flvtd_pkg::in_item_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output flvtd_pkg::out_item_t      out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_idx_i,
  input  wire logic [23:0]          cfg_data_i
);

  localparam int unsigned CW = flvtd_pkg::FIFO_AW + 1;

  // Configuration registers
  logic [23:0] max_size_q, flush_thr_q;

  // Parser state
  flvtd_pkg::phase_e phase_q, phase_d;
  logic [3:0]  fc_q, fc_d;
  logic [7:0]  type_q, type_d;
  logic [23:0] rem_q, rem_d;
  logic [23:0] plen_q, plen_d;
  logic [31:0] time_q, time_d;
  logic [31:0] tv_q, tv_d;
  logic [31:0] bsf_q, bsf_d;

  // Result queue
  flvtd_pkg::out_item_t        fifo_q [flvtd_pkg::FIFO_DEPTH];
  logic [flvtd_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]                 cnt_q;

  logic                 accept, pop;
  logic                 main_vld, flush_vld;
  flvtd_pkg::out_item_t main_res, flush_res, slot0, slot1;
  logic [1:0]           push_n;
  logic                 bad_sig;
  logic [31:0]          tv_new;

  assign accept      = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign in_ready_o  = cnt_q <= CW'(flvtd_pkg::FIFO_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = fifo_q[rd_ptr_q];

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q  <= flvtd_pkg::MAX_TAG_SIZE_RST;
      flush_thr_q <= flvtd_pkg::FLUSH_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        flvtd_pkg::REG_MAX_TAG_SIZE:    max_size_q  <= cfg_data_i;
        flvtd_pkg::REG_FLUSH_THRESHOLD: flush_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Parse one byte: next state and results
  always_comb begin
    phase_d  = phase_q;
    fc_d     = fc_q;
    type_d   = type_q;
    rem_d    = rem_q;
    plen_d   = plen_q;
    time_d   = time_q;
    tv_d     = tv_q;
    bsf_d    = bsf_q;
    main_vld = 1'b0;
    main_res = '0;
    bad_sig  = 1'b0;
    tv_new   = {tv_q[23:0], in_data_i.data_byte};

    unique case (phase_q)
      flvtd_pkg::PH_FILE: begin
        bad_sig = (fc_q == 4'd0 && in_data_i.data_byte != flvtd_pkg::SIG_F) ||
                  (fc_q == 4'd1 && in_data_i.data_byte != flvtd_pkg::SIG_L) ||
                  (fc_q == 4'd2 && in_data_i.data_byte != flvtd_pkg::SIG_V);
        if (bad_sig) begin
          main_vld            = 1'b1;
          main_res.kind       = flvtd_pkg::KIND_ERROR;
          main_res.tag_type   = type_q;
          main_res.timestamp  = time_q;
          main_res.error_code = flvtd_pkg::ERR_BAD_HEADER;
          fc_d                = '0;
        end else if (fc_q == 4'(flvtd_pkg::FILE_HDR_LEN - 1)) begin
          fc_d    = '0;
          phase_d = flvtd_pkg::PH_TAG;
        end else begin
          fc_d = fc_q + 4'd1;
        end
      end
      flvtd_pkg::PH_TAG: begin
        // capture header fields
        case (fc_q)
          4'd0: type_d = in_data_i.data_byte;
          4'd1: rem_d  = {in_data_i.data_byte, 16'd0};
          4'd2: rem_d  = {rem_q[23:16], in_data_i.data_byte, 8'd0};
          4'd3: rem_d  = {rem_q[23:8], in_data_i.data_byte};
          4'd4: time_d = {8'd0, in_data_i.data_byte, 16'd0};
          4'd5: time_d = {time_q[31:16], in_data_i.data_byte, 8'd0};
          4'd6: time_d = {time_q[31:8], in_data_i.data_byte};
          4'd7: time_d = {in_data_i.data_byte, time_q[23:0]};
          default: ;
        endcase
        if (fc_q == 4'd3 && rem_d > max_size_q) begin
          main_vld            = 1'b1;
          main_res.kind       = flvtd_pkg::KIND_ERROR;
          main_res.tag_type   = type_d;
          main_res.timestamp  = time_d;
          main_res.error_code = flvtd_pkg::ERR_OVERSIZE;
          fc_d                = '0;
        end else if (fc_q == 4'(flvtd_pkg::TAG_HDR_LEN - 1)) begin
          fc_d    = '0;
          plen_d  = rem_q;
          tv_d    = '0;
          phase_d = (rem_q == '0) ? flvtd_pkg::PH_TRAIL : flvtd_pkg::PH_BODY;
        end else begin
          fc_d = fc_q + 4'd1;
        end
      end
      flvtd_pkg::PH_BODY: begin
        main_vld              = 1'b1;
        main_res.kind         = flvtd_pkg::KIND_PAYLOAD;
        main_res.payload_byte = in_data_i.data_byte;
        main_res.tag_type     = type_q;
        main_res.timestamp    = time_q;
        if (bsf_q != '1) begin
          bsf_d = bsf_q + 32'd1;
        end
        if (rem_q != '0) begin
          rem_d = rem_q - 24'd1;
        end
        if (rem_d == '0) begin
          phase_d = flvtd_pkg::PH_TRAIL;
          fc_d    = '0;
          tv_d    = '0;
        end
      end
      flvtd_pkg::PH_TRAIL: begin
        tv_d = tv_new;
        if (fc_q == 4'(flvtd_pkg::TRAILER_LEN - 1)) begin
          main_vld               = 1'b1;
          main_res.kind          = flvtd_pkg::KIND_END;
          main_res.tag_type      = type_q;
          main_res.timestamp     = time_q;
          main_res.tag_accepted  = (type_q == flvtd_pkg::TAG_AUDIO) ||
                                   (type_q == flvtd_pkg::TAG_VIDEO) ||
                                   (type_q == flvtd_pkg::TAG_SCRIPT);
          main_res.size_mismatch =
            tv_new != ({8'd0, plen_q} + 32'(flvtd_pkg::TAG_HDR_LEN));
          fc_d    = '0;
          phase_d = flvtd_pkg::PH_TAG;
        end else begin
          fc_d = fc_q + 4'd1;
        end
      end
      default: ;
    endcase

    // Raise a flush at chunk end once the count reaches the threshold
    flush_vld      = in_data_i.chunk_last && (bsf_d >= {8'd0, flush_thr_q});
    flush_res      = '0;
    flush_res.kind = flvtd_pkg::KIND_FLUSH;
    flush_res.last = 1'b1;
    if (flush_vld) begin
      bsf_d = '0;
    end
    main_res.last = !flush_vld;

    slot0  = main_vld ? main_res : flush_res;
    slot1  = flush_res;
    push_n = {1'b0, main_vld} + {1'b0, flush_vld};
  end

  // Advance parser state on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= flvtd_pkg::PH_FILE;
      fc_q    <= '0;
      type_q  <= '0;
      rem_q   <= '0;
      plen_q  <= '0;
      time_q  <= '0;
      tv_q    <= '0;
      bsf_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      fc_q    <= fc_d;
      type_q  <= type_d;
      rem_q   <= rem_d;
      plen_q  <= plen_d;
      time_q  <= time_d;
      tv_q    <= tv_d;
      bsf_q   <= bsf_d;
    end
  end

  // Store results in the queue
  always_ff @(posedge clk_i) begin
    if (accept && push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= slot0;
    end
    if (accept && push_n == 2'd2) begin
      fifo_q[wr_ptr_q + flvtd_pkg::FIFO_AW'(1)] <= slot1;
    end
  end

  // Track queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (accept) begin
        wr_ptr_q <= wr_ptr_q + flvtd_pkg::FIFO_AW'(push_n);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + flvtd_pkg::FIFO_AW'(1);
      end
      cnt_q <= cnt_q + (accept ? CW'(push_n) : CW'(0)) - (pop ? CW'(1) : CW'(0));
    end
  end

  // Queue level follows pushes and pops
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_q) + ($past(accept) ? CW'($past(push_n)) : CW'(0))
                      - ($past(pop) ? CW'(1) : CW'(0)))
    else $error("result queue level out of step");

  // Queue never overfills
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(flvtd_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // Payload phase always has bytes left
  a_body_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == flvtd_pkg::PH_BODY |-> rem_q != '0)
    else $error("payload phase with zero bytes left");

  // Field counter stays within the current frame
  a_fc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == flvtd_pkg::PH_TRAIL |-> fc_q < 4'(flvtd_pkg::TRAILER_LEN)) and
    (phase_q == flvtd_pkg::PH_TAG   |-> fc_q < 4'(flvtd_pkg::TAG_HDR_LEN)) and
    (phase_q == flvtd_pkg::PH_FILE  |-> fc_q < 4'(flvtd_pkg::FILE_HDR_LEN)))
    else $error("field counter out of range");

endmodule

`default_nettype wire
